// File: rtl/pfa_pkg.sv
// Package with the shared constants, types and codes of the Pareto front archive.
`timescale 1ns / 1ps

package pfa_pkg;

  // Archive geometry and field widths.
  localparam int FRONT_DEPTH = 128;
  localparam int COST_WIDTH  = 32;
  localparam int TAG_WIDTH   = 16;
  localparam int IDX_WIDTH   = 7;
  localparam int OCNT_WIDTH  = 8;
  localparam int ADDR_W      = $clog2(FRONT_DEPTH);
  localparam int CNT_W       = $clog2(FRONT_DEPTH + 1);

  typedef logic [COST_WIDTH-1:0] cost_t;
  typedef logic [TAG_WIDTH-1:0]  tag_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_WIDTH-1:0]  idx_t;
  typedef logic [OCNT_WIDTH-1:0] ocnt_t;

  // Request codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // One stored front entry.
  typedef struct packed {
    cost_t c1;
    cost_t c2;
    tag_t  tag;
  } entry_t;

  // Verdicts of the shared compare unit.
  typedef struct packed {
    logic ent_dom;   // stored entry dominates the candidate
    logic cand_dom;  // candidate strictly beats the stored entry
  } cmp_res_t;

  // One result item.
  typedef struct packed {
    logic  accepted;
    logic  dominated;
    logic  full_drop;
    ocnt_t removed_count;
    ocnt_t front_count;
    logic  rd_valid;
    cost_t rd_first_cost;
    cost_t rd_second_cost;
    tag_t  rd_tag;
  } res_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOM_SCAN,
    ST_COMPACT,
    ST_APPEND,
    ST_RD_WAIT,
    ST_FINISH
  } state_t;

endpackage

// File: rtl/pfa_if.sv
// Channel interfaces for insert/read requests and for results.
`timescale 1ns / 1ps

interface pfa_in_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  pfa_pkg::cost_t    first_cost;
  pfa_pkg::cost_t    second_cost;
  pfa_pkg::tag_t     cand_tag;
  pfa_pkg::idx_t     read_index;

  modport source (output valid, req_type, first_cost, second_cost, cand_tag, read_index,
                  input ready);
  modport sink   (input valid, req_type, first_cost, second_cost, cand_tag, read_index,
                  output ready);
endinterface

interface pfa_out_if;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              dominated;
  logic              full_drop;
  pfa_pkg::ocnt_t    removed_count;
  pfa_pkg::ocnt_t    front_count;
  logic              rd_valid;
  pfa_pkg::cost_t    rd_first_cost;
  pfa_pkg::cost_t    rd_second_cost;
  pfa_pkg::tag_t     rd_tag;

  modport source (output valid, accepted, dominated, full_drop, removed_count, front_count,
                  rd_valid, rd_first_cost, rd_second_cost, rd_tag,
                  input ready);
  modport sink   (input valid, accepted, dominated, full_drop, removed_count, front_count,
                  rd_valid, rd_first_cost, rd_second_cost, rd_tag,
                  output ready);
endinterface

// File: rtl/pfa_ram.sv
// Front storage: one write port and one registered read port.
`timescale 1ns / 1ps

module pfa_ram (
  input  logic             clk,
  input  logic             wr_en,
  input  pfa_pkg::addr_t   wr_addr,
  input  pfa_pkg::entry_t  wr_data,
  input  logic             rd_en,
  input  pfa_pkg::addr_t   rd_addr,
  output pfa_pkg::entry_t  rd_data
);

  pfa_pkg::entry_t mem [pfa_pkg::FRONT_DEPTH];
  pfa_pkg::entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/pfa_cmp.sv
// Shared dominance compare unit, used once per stored entry in each pass.
`timescale 1ns / 1ps

module pfa_cmp (
  input  pfa_pkg::cost_t    cand_c1,
  input  pfa_pkg::cost_t    cand_c2,
  input  pfa_pkg::entry_t   ent,
  output pfa_pkg::cmp_res_t res
);

  // The entry rejects the candidate when it is no worse on the first cost and
  // strictly better on the second; the candidate removes an entry only when it
  // is strictly better on both.
  always_comb begin
    res.ent_dom  = (ent.c1 <= cand_c1) && (ent.c2 < cand_c2);
    res.cand_dom = (cand_c1 < ent.c1) && (cand_c2 < ent.c2);
  end

endmodule

// File: rtl/pareto_front_archive_top.sv
// Top level of the two-objective Pareto front archive with its sequencer.
`timescale 1ns / 1ps

// The archive holds up to 128 (cost1, cost2, tag) entries in one RAM and handles
// one transaction at a time. An insert walks the stored entries twice through a
// single compare unit, one entry per cycle behind the RAM's registered read:
// first to see whether any entry dominates the candidate, then to drop the
// entries the candidate beats and compact the survivors in place. A dominated
// candidate skips the second walk. The input is ready again once the finished
// result has moved into the output register, so a new transaction may be taken
// while that result still waits on the output side.
module pareto_front_archive_top (
  input  logic        clk,
  input  logic        rst_n,
  pfa_in_if.sink      in_ch,
  pfa_out_if.source   out_ch
);

  pfa_pkg::state_t   state_r, state_nxt;
  pfa_pkg::cnt_t     count_r, count_nxt;
  pfa_pkg::cnt_t     ptr_r, ptr_nxt;
  pfa_pkg::cnt_t     w_r, w_nxt;
  pfa_pkg::cnt_t     rmv_r, rmv_nxt;
  logic              pend_r, pend_nxt;
  logic              dom_r, dom_nxt;
  logic              rdv_r, rdv_nxt;
  pfa_pkg::entry_t   cand_r, cand_nxt;
  pfa_pkg::res_t     res_r, res_nxt;
  pfa_pkg::res_t     out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              ram_wr_en;
  pfa_pkg::addr_t    ram_wr_addr;
  pfa_pkg::entry_t   ram_wr_data;
  logic              ram_rd_en;
  pfa_pkg::addr_t    ram_rd_addr;
  pfa_pkg::entry_t   ram_rd_data;
  pfa_pkg::cmp_res_t cmp;

  // Entry storage.
  pfa_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Shared compare unit sees the candidate against the entry just read.
  pfa_cmp u_cmp (
    .cand_c1 (cand_r.c1),
    .cand_c2 (cand_r.c2),
    .ent     (ram_rd_data),
    .res     (cmp)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfa_pkg::ST_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      w_r         <= '0;
      rmv_r       <= '0;
      pend_r      <= 1'b0;
      dom_r       <= 1'b0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      w_r         <= w_nxt;
      rmv_r       <= rmv_nxt;
      pend_r      <= pend_nxt;
      dom_r       <= dom_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // Sequencer: next state, RAM control and result assembly.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    w_nxt         = w_r;
    rmv_nxt       = rmv_r;
    pend_nxt      = pend_r;
    dom_nxt       = dom_r;
    rdv_nxt       = rdv_r;
    cand_nxt      = cand_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = w_r[pfa_pkg::ADDR_W-1:0];
    ram_wr_data   = ram_rd_data;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = ptr_r[pfa_pkg::ADDR_W-1:0];
    in_ch.ready   = 1'b0;

    unique case (state_r)
      pfa_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cand_nxt.c1  = in_ch.first_cost;
          cand_nxt.c2  = in_ch.second_cost;
          cand_nxt.tag = in_ch.cand_tag;
          res_nxt      = '0;
          if (in_ch.req_type == pfa_pkg::REQ_READ) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pfa_pkg::addr_t'(in_ch.read_index);
            rdv_nxt     = 32'(in_ch.read_index) < 32'(count_r);
            state_nxt   = pfa_pkg::ST_RD_WAIT;
          end else begin
            ptr_nxt   = '0;
            pend_nxt  = 1'b0;
            dom_nxt   = 1'b0;
            state_nxt = pfa_pkg::ST_DOM_SCAN;
          end
        end
      end

      // First pass: look for a stored entry that dominates the candidate.
      pfa_pkg::ST_DOM_SCAN: begin
        pend_nxt = 1'b0;
        if (ptr_r < count_r) begin
          ram_rd_en = 1'b1;
          ptr_nxt   = ptr_r + 1'b1;
          pend_nxt  = 1'b1;
        end
        if (pend_r && cmp.ent_dom) begin
          dom_nxt = 1'b1;
        end
        if (!(ptr_r < count_r) && !pend_r) begin
          if (dom_r) begin
            res_nxt.dominated   = 1'b1;
            res_nxt.front_count = pfa_pkg::ocnt_t'(count_r);
            state_nxt           = pfa_pkg::ST_FINISH;
          end else begin
            ptr_nxt   = '0;
            w_nxt     = '0;
            rmv_nxt   = '0;
            state_nxt = pfa_pkg::ST_COMPACT;
          end
        end
      end

      // Second pass: drop beaten entries and write survivors back in order.
      pfa_pkg::ST_COMPACT: begin
        pend_nxt = 1'b0;
        if (ptr_r < count_r) begin
          ram_rd_en = 1'b1;
          ptr_nxt   = ptr_r + 1'b1;
          pend_nxt  = 1'b1;
        end
        if (pend_r) begin
          if (cmp.cand_dom) begin
            rmv_nxt = rmv_r + 1'b1;
          end else begin
            ram_wr_en = 1'b1;
            w_nxt     = w_r + 1'b1;
          end
        end
        if (!(ptr_r < count_r) && !pend_r) begin
          state_nxt = pfa_pkg::ST_APPEND;
        end
      end

      // Append the candidate if room is left after the removals.
      pfa_pkg::ST_APPEND: begin
        res_nxt.removed_count = pfa_pkg::ocnt_t'(rmv_r);
        if (32'(w_r) < pfa_pkg::FRONT_DEPTH) begin
          ram_wr_en           = 1'b1;
          ram_wr_data         = cand_r;
          count_nxt           = w_r + 1'b1;
          res_nxt.accepted    = 1'b1;
          res_nxt.front_count = pfa_pkg::ocnt_t'(w_r + 1'b1);
        end else begin
          count_nxt           = w_r;
          res_nxt.full_drop   = 1'b1;
          res_nxt.front_count = pfa_pkg::ocnt_t'(w_r);
        end
        state_nxt = pfa_pkg::ST_FINISH;
      end

      // Read data has arrived from the RAM.
      pfa_pkg::ST_RD_WAIT: begin
        res_nxt.rd_valid    = rdv_r;
        res_nxt.front_count = pfa_pkg::ocnt_t'(count_r);
        if (rdv_r) begin
          res_nxt.rd_first_cost  = ram_rd_data.c1;
          res_nxt.rd_second_cost = ram_rd_data.c2;
          res_nxt.rd_tag         = ram_rd_data.tag;
        end
        state_nxt = pfa_pkg::ST_FINISH;
      end

      // Move the result into the output register once it is free.
      pfa_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = pfa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pfa_pkg::ST_IDLE;
      end
    endcase
  end

  // Output channel.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = out_r.accepted;
  assign out_ch.dominated      = out_r.dominated;
  assign out_ch.full_drop      = out_r.full_drop;
  assign out_ch.removed_count  = out_r.removed_count;
  assign out_ch.front_count    = out_r.front_count;
  assign out_ch.rd_valid       = out_r.rd_valid;
  assign out_ch.rd_first_cost  = out_r.rd_first_cost;
  assign out_ch.rd_second_cost = out_r.rd_second_cost;
  assign out_ch.rd_tag         = out_r.rd_tag;

  // The stored count never passes the archive depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= pfa_pkg::FRONT_DEPTH)
    else $error("entry count exceeds archive depth");

  // Compaction never writes ahead of the entry being read.
  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pfa_pkg::ST_COMPACT |-> w_r <= ptr_r)
    else $error("compaction write pointer passed read pointer");

  // An accepted transaction always starts work, so the input is not ready next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input ready right after a transaction was taken");

  // A dropped candidate only happens with a full front.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.full_drop |->
      32'(out_ch.front_count) == (pfa_pkg::FRONT_DEPTH % 256) && !out_ch.accepted)
    else $error("full drop reported with room left");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the two-objective Pareto front archive.
`timescale 1ns / 1ps

module testbench;

  localparam int             RANDOM_ITEMS = 1300;
  localparam int             DIR_ROWS     = 20;
  localparam int             MAX_EPOCHS   = 112;
  localparam logic [31:0]    BOX_SPAN     = 32'h0200_0000;
  localparam logic [31:0]    TOP_BASE     = 32'hF000_0000;
  localparam logic [31:0]    DIR_BASE     = 32'hFF00_0000;
  localparam pfa_pkg::cost_t COST_MAX     = '1;
  localparam int             CYCLE_LIMIT  = 3_000_000;
  localparam int             DRAIN_CYCLES = 300;
  localparam int             REPORT_MAX   = 10;
  localparam int             IDLE_PCT[4]  = '{0, 56, 0, 37};
  localparam int             STALL_PCT[4] = '{0, 0, 56, 37};

  // One request as the sender sees it.
  typedef struct {
    logic           op;
    pfa_pkg::cost_t c1;
    pfa_pkg::cost_t c2;
    pfa_pkg::tag_t  tag;
    pfa_pkg::idx_t  idx;
  } archive_req_t;

  // Directed row; the typed outcome is used only where typed is set.
  typedef struct {
    archive_req_t  rq;
    bit            typed;
    pfa_pkg::res_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   cycles = 0;
  int   fail_count = 0;
  int   results_checked = 0;
  int   items_sent;

  // Shadow copy of the archive contents.
  pfa_pkg::cost_t front_first [pfa_pkg::FRONT_DEPTH];
  pfa_pkg::cost_t front_second [pfa_pkg::FRONT_DEPTH];
  pfa_pkg::tag_t  front_tag [pfa_pkg::FRONT_DEPTH];
  int             front_len;

  // Outcomes still owed by the block, oldest first.
  pfa_pkg::res_t outcome_q[$];

  // Run statistics for the summary.
  int n_insert, n_append, n_reject, n_drop, n_removed, n_read, n_read_hit, peak_front;

  pfa_in_if  in_ch ();
  pfa_out_if out_ch ();

  pareto_front_archive_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Computes the outcome of one request and updates the shadow front.
  function automatic pfa_pkg::res_t archive_outcome(input archive_req_t rq);
    pfa_pkg::res_t r;
    bit            beaten;
    int            w;
    int            i;
    r = '0;
    if (rq.op == pfa_pkg::REQ_READ) begin
      if (int'(rq.idx) < front_len) begin
        r.rd_valid       = 1'b1;
        r.rd_first_cost  = front_first[rq.idx];
        r.rd_second_cost = front_second[rq.idx];
        r.rd_tag         = front_tag[rq.idx];
      end
      r.front_count = pfa_pkg::ocnt_t'(front_len);
      return r;
    end
    // Rejected if some entry is no worse on the first cost and better on the second.
    beaten = 1'b0;
    for (i = 0; i < front_len; i++) begin
      if (front_first[i] <= rq.c1 && front_second[i] < rq.c2) beaten = 1'b1;
    end
    r.dominated = beaten;
    if (!beaten) begin
      // Drop every entry beaten on both costs and close the gaps in order.
      w = 0;
      for (i = 0; i < front_len; i++) begin
        if (rq.c1 < front_first[i] && rq.c2 < front_second[i]) begin
          r.removed_count = r.removed_count + 1'b1;
        end else begin
          front_first[w]  = front_first[i];
          front_second[w] = front_second[i];
          front_tag[w]    = front_tag[i];
          w++;
        end
      end
      front_len = w;
      if (front_len < pfa_pkg::FRONT_DEPTH) begin
        front_first[front_len]  = rq.c1;
        front_second[front_len] = rq.c2;
        front_tag[front_len]    = rq.tag;
        front_len++;
        r.accepted = 1'b1;
      end else begin
        r.full_drop = 1'b1;
      end
    end
    r.front_count = pfa_pkg::ocnt_t'(front_len);
    return r;
  endfunction

  function automatic string show_result(input pfa_pkg::res_t r);
    return $sformatf({"acc=%0b dom=%0b drop=%0b removed=%0d count=%0d ",
                      "rd_valid=%0b c1=%h c2=%h tag=%h"},
                     r.accepted, r.dominated, r.full_drop, r.removed_count, r.front_count,
                     r.rd_valid, r.rd_first_cost, r.rd_second_cost, r.rd_tag);
  endfunction

  // Presents one request after a random gap and waits for its transaction.
  task automatic offer(input archive_req_t rq, input bit typed, input pfa_pkg::res_t want);
    pfa_pkg::res_t model;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= rq.op;
    in_ch.first_cost  <= rq.c1;
    in_ch.second_cost <= rq.c2;
    in_ch.cand_tag    <= rq.tag;
    in_ch.read_index  <= rq.idx;
    do @(posedge clk); while (!in_ch.ready);
    model = archive_outcome(rq);
    outcome_q.push_back(typed ? want : model);
    items_sent++;
    if (rq.op == pfa_pkg::REQ_READ) begin
      n_read++;
      n_read_hit += model.rd_valid;
    end else begin
      n_insert++;
      n_append  += model.accepted;
      n_reject  += model.dominated;
      n_drop    += model.full_drop;
      n_removed += model.removed_count;
    end
    if (front_len > peak_front) peak_front = front_len;
  endtask

  // Holds the sender off until every owed outcome has been seen.
  task automatic wait_for_outcomes();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  // Receiver side: ready follows the current stall rate, low during reset.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each result transaction with the oldest owed outcome.
  always @(posedge clk) begin : check_results
    pfa_pkg::res_t seen;
    pfa_pkg::res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.accepted, out_ch.dominated, out_ch.full_drop, out_ch.removed_count,
              out_ch.front_count, out_ch.rd_valid, out_ch.rd_first_cost,
              out_ch.rd_second_cost, out_ch.rd_tag};
      if (outcome_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("ERROR %0t: result with nothing outstanding: %s",
                   $realtime, show_result(seen));
        end
      end else begin
        want = outcome_q.pop_front();
        results_checked++;
        if (seen !== want) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("ERROR %0t: result %0d differs", $realtime, results_checked);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(seen));
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d outcomes outstanding",
               cycles, outcome_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Reset, directed table, then random epochs.
  initial begin : stimulus
    stim_row_t      dir_tab [DIR_ROWS];
    archive_req_t   rq;
    pfa_pkg::cost_t base;
    pfa_pkg::cost_t x;
    pfa_pkg::cost_t y;
    logic [31:0]    step_max;
    int             epoch;
    int             phase;
    int             last_phase;
    int             steps;
    int             n_mix;
    int             pick;
    int             j;
    bit             fill;

    items_sent      = 0;
    front_len       = 0;
    peak_front      = 0;
    n_insert = 0; n_append = 0; n_reject = 0; n_drop = 0;
    n_removed = 0; n_read = 0; n_read_hit = 0;
    idle_pct  = 0;
    stall_pct = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= pfa_pkg::REQ_INSERT;
    in_ch.first_cost  <= '0;
    in_ch.second_cost <= '0;
    in_ch.cand_tag    <= '0;
    in_ch.read_index  <= '0;

    // Extremes, equal costs, rejection, removal, reads past the end.
    dir_tab = '{
      '{'{pfa_pkg::REQ_READ, '0, '0, '0, 7'd0}, 1'b1, pfa_pkg::res_t'(0)},
      '{'{pfa_pkg::REQ_READ, COST_MAX, COST_MAX, 16'hFFFF, 7'd127}, 1'b1,
        pfa_pkg::res_t'(0)},
      '{'{pfa_pkg::REQ_INSERT, DIR_BASE + 100, DIR_BASE + 100, 16'hFFFF, 7'd127}, 1'b1,
        pfa_pkg::res_t'{accepted: 1'b1, front_count: 8'd1, default: 0}},
      '{'{pfa_pkg::REQ_READ, '0, '0, '0, 7'd0}, 1'b1,
        pfa_pkg::res_t'{front_count: 8'd1, rd_valid: 1'b1, rd_first_cost: DIR_BASE + 100,
                        rd_second_cost: DIR_BASE + 100, rd_tag: 16'hFFFF, default: 0}},
      '{'{pfa_pkg::REQ_INSERT, DIR_BASE + 100, DIR_BASE + 100, 16'h0001, 7'd0}, 1'b1,
        pfa_pkg::res_t'{accepted: 1'b1, front_count: 8'd2, default: 0}},
      '{'{pfa_pkg::REQ_INSERT, DIR_BASE + 100, DIR_BASE + 101, 16'h0002, 7'd0}, 1'b1,
        pfa_pkg::res_t'{dominated: 1'b1, front_count: 8'd2, default: 0}},
      '{'{pfa_pkg::REQ_INSERT, DIR_BASE + 101, DIR_BASE + 100, 16'h0003, 7'd0}, 1'b0,
        pfa_pkg::res_t'(0)},
      '{'{pfa_pkg::REQ_INSERT, DIR_BASE + 99, DIR_BASE + 200, 16'h0004, 7'd0}, 1'b0,
        pfa_pkg::res_t'(0)},
      '{'{pfa_pkg::REQ_INSERT, DIR_BASE + 50, DIR_BASE + 50, 16'h0005, 7'd0}, 1'b1,
        pfa_pkg::res_t'{accepted: 1'b1, removed_count: 8'd4, front_count: 8'd1,
                        default: 0}},
      '{'{pfa_pkg::REQ_READ, '0, '0, '0, 7'd0}, 1'b1,
        pfa_pkg::res_t'{front_count: 8'd1, rd_valid: 1'b1, rd_first_cost: DIR_BASE + 50,
                        rd_second_cost: DIR_BASE + 50, rd_tag: 16'h0005, default: 0}},
      '{'{pfa_pkg::REQ_READ, '0, '0, '0, 7'd1}, 1'b1,
        pfa_pkg::res_t'{front_count: 8'd1, default: 0}},
      '{'{pfa_pkg::REQ_INSERT, COST_MAX, COST_MAX, 16'h0000, 7'd0}, 1'b1,
        pfa_pkg::res_t'{dominated: 1'b1, front_count: 8'd1, default: 0}},
      '{'{pfa_pkg::REQ_INSERT, '0, COST_MAX, 16'hAAAA, 7'd0}, 1'b0, pfa_pkg::res_t'(0)},
      '{'{pfa_pkg::REQ_INSERT, COST_MAX, '0, 16'h5555, 7'd0}, 1'b0, pfa_pkg::res_t'(0)},
      '{'{pfa_pkg::REQ_INSERT, COST_MAX, 32'd1, 16'h8001, 7'd0}, 1'b0, pfa_pkg::res_t'(0)},
      '{'{pfa_pkg::REQ_READ, '0, '0, '0, 7'd2}, 1'b0, pfa_pkg::res_t'(0)},
      '{'{pfa_pkg::REQ_READ, '0, '0, '0, 7'd3}, 1'b1,
        pfa_pkg::res_t'{front_count: 8'd3, default: 0}},
      '{'{pfa_pkg::REQ_INSERT, DIR_BASE + 40, DIR_BASE + 40, 16'h0006, 7'd0}, 1'b0,
        pfa_pkg::res_t'(0)},
      '{'{pfa_pkg::REQ_READ, '0, '0, '0, 7'd0}, 1'b0, pfa_pkg::res_t'(0)},
      '{'{pfa_pkg::REQ_READ, '0, '0, '0, 7'd127}, 1'b0, pfa_pkg::res_t'(0)}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) offer(dir_tab[k].rq, dir_tab[k].typed, dir_tab[k].want);

    // Each epoch works in a cost box below the previous one, so its first insert
    // clears the old entries. The entry with zero first cost and the one with
    // zero second cost stay at the head of the front for good.
    epoch      = 0;
    last_phase = -1;
    while (items_sent - DIR_ROWS < RANDOM_ITEMS && epoch < MAX_EPOCHS) begin
      phase = (items_sent - DIR_ROWS) * 4 / RANDOM_ITEMS;
      if (phase > 3) phase = 3;
      if (phase != last_phase || $urandom_range(0, 5) == 0) wait_for_outcomes();
      last_phase = phase;
      idle_pct   = IDLE_PCT[phase];
      stall_pct  = STALL_PCT[phase];

      base     = TOP_BASE - epoch * BOX_SPAN;
      fill     = (epoch % 24 == 5);
      steps    = fill ? 135 : $urandom_range(1, 10);
      step_max = fill ? BOX_SPAN / 512 : BOX_SPAN / 64;
      x        = base + $urandom_range(0, BOX_SPAN / 4);
      y        = base + BOX_SPAN - 1 - $urandom_range(0, BOX_SPAN / 4);

      // Staircase: each step is better on one cost and worse on the other.
      for (int s = 0; s < steps; s++) begin
        rq = '{pfa_pkg::REQ_INSERT, x, y, pfa_pkg::tag_t'($urandom_range(0, 65535)),
               pfa_pkg::idx_t'($urandom_range(0, 127))};
        offer(rq, 1'b0, pfa_pkg::res_t'(0));
        x = x + $urandom_range(1, step_max);
        y = y - $urandom_range(1, step_max);
      end

      // Mixed traffic against the front that the staircase built.
      n_mix = fill ? 16 : $urandom_range(8, 20);
      for (int m = 0; m < n_mix; m++) begin
        pick = $urandom_range(0, 99);
        rq.op  = pfa_pkg::REQ_INSERT;
        rq.c1  = $urandom();
        rq.c2  = $urandom();
        rq.tag = pfa_pkg::tag_t'($urandom_range(0, 65535));
        rq.idx = pfa_pkg::idx_t'($urandom_range(0, 127));
        j      = (front_len > 2) ? $urandom_range(2, front_len - 1) : -1;
        if (pick < 25) begin
          rq.op = pfa_pkg::REQ_READ;
          if ($urandom_range(0, 4) != 0) begin
            rq.idx = pfa_pkg::idx_t'($urandom_range(0,
                       (front_len + 1 > 127) ? 127 : front_len + 1));
          end
        end else if (pick < 40 && j >= 0) begin
          rq.c1 = front_first[j];
          rq.c2 = front_second[j];
        end else if (pick < 60 && j >= 0) begin
          rq.c1 = front_first[j] + $urandom_range(0, 4096);
          rq.c2 = front_second[j] + $urandom_range(1, 4096);
        end else if (pick < 70) begin
          rq.c1 = x;
          rq.c2 = y;
          x = x + $urandom_range(1, step_max);
          y = y - $urandom_range(1, step_max);
        end else begin
          rq.c1 = base + $urandom_range(0, BOX_SPAN - 1);
          rq.c2 = base + $urandom_range(0, BOX_SPAN - 1);
        end
        offer(rq, 1'b0, pfa_pkg::res_t'(0));
      end
      epoch++;
    end

    wait_for_outcomes();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d inserts over %0d epochs: %0d appended, %0d rejected, %0d dropped when full,",
             n_insert, epoch, n_append, n_reject, n_drop);
    $display("%0d entries removed; %0d reads (%0d in range); largest front %0d; %0d checked.",
             n_removed, n_read, n_read_hit, peak_front, results_checked);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pfa_pkg.sv
rtl/pfa_if.sv
rtl/pfa_ram.sv
rtl/pfa_cmp.sv
rtl/pareto_front_archive_top.sv
test/testbench.sv
